/* design/lcd_mode_timing_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// LCD mode timing sequencer - assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LCD_MODE_TIMING_SEQUENCER_DEFINES_SVH
`define LCD_MODE_TIMING_SEQUENCER_DEFINES_SVH

// check a condition at every clock edge
`define LMTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition in one cycle implies another in the next
`define LMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/lmts_pkg.sv */
// ----------------------------------------------------------------------------
// LCD mode timing sequencer - package
// Types, phase lengths and mode codes shared by the sequencer modules.
// ----------------------------------------------------------------------------
package lmts_pkg;

	localparam int ACC_W   = 16;
	localparam int LINE_W  = 8;
	localparam int MCYC_W  = 10;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 16;

	localparam logic [ACC_W-1:0]  OAM_DOTS      = ACC_W'(80);
	localparam logic [ACC_W-1:0]  DRAW_DOTS     = ACC_W'(172);
	localparam logic [ACC_W-1:0]  HBLANK_DOTS   = ACC_W'(204);
	localparam logic [ACC_W-1:0]  LINE_DOTS     = ACC_W'(456);
	localparam logic [LINE_W-1:0] VISIBLE_LINES = LINE_W'(144);
	localparam logic [LINE_W-1:0] TOTAL_LINES   = LINE_W'(154);

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_DRAW   = 2'd3
	} mode_t;

	// first field in the highest bits
	typedef struct packed {
		logic [LINE_W-1:0] compare_line;
		logic              compare_irq_enable;
		logic              oam_irq_enable;
		logic              vblank_stat_enable;
		logic              hblank_irq_enable;
		logic              lcd_enable;
		logic [MCYC_W-1:0] elapsed_mcycles;
	} in_item_t;

	typedef struct packed {
		logic              draw_line;
		logic              vblank_irq;
		logic              lcd_irq;
		logic              coincidence;
		logic [LINE_W-1:0] line;
		mode_t             mode;
	} out_item_t;

	typedef struct packed {
		logic [ACC_W-1:0]  acc;
		mode_t             mode;
		logic [LINE_W-1:0] line;
		logic              coinc;
	} seq_state_t;

endpackage

/* design/lmts_step.sv */
// ----------------------------------------------------------------------------
// LCD mode timing sequencer - step logic
// Next state and result for one time step: saturating dot add, one mode
// transition at most, line advance, interrupts and the line compare.
// ----------------------------------------------------------------------------
module lmts_step
	import lmts_pkg::*;
(
	input  in_item_t   item,
	input  seq_state_t cur,
	output seq_state_t nxt,
	output out_item_t  res
);

	logic [ACC_W:0]    sum;
	logic [ACC_W-1:0]  sat;
	logic [ACC_W-1:0]  thr;
	logic [ACC_W-1:0]  diff;
	logic              phase_done;
	logic [LINE_W-1:0] line_inc;
	logic [LINE_W-1:0] line_new;
	mode_t             mode_new;
	logic              lcd_irq;
	logic              vb_irq;
	logic              drawn;
	logic              match;

	assign sum = {1'b0, cur.acc} + (ACC_W+1)'({item.elapsed_mcycles, 2'b00});
	assign sat = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];

	always_comb begin
		case (cur.mode)
			MODE_OAM:    thr = OAM_DOTS;
			MODE_DRAW:   thr = DRAW_DOTS;
			MODE_HBLANK: thr = HBLANK_DOTS;
			default:     thr = LINE_DOTS;
		endcase
	end

	assign phase_done = (sat >= thr);
	assign diff       = sat - thr;
	assign line_inc   = cur.line + LINE_W'(1);

	always_comb begin
		mode_new = cur.mode;
		line_new = cur.line;
		lcd_irq  = 1'b0;
		vb_irq   = 1'b0;
		drawn    = 1'b0;
		if (phase_done) begin
			case (cur.mode)
				MODE_OAM: begin
					mode_new = MODE_DRAW;
				end
				MODE_DRAW: begin
					mode_new = MODE_HBLANK;
					drawn    = 1'b1;
					lcd_irq  = item.hblank_irq_enable;
				end
				MODE_HBLANK: begin
					line_new = line_inc;
					if (line_inc == VISIBLE_LINES) begin
						mode_new = MODE_VBLANK;
						vb_irq   = 1'b1;
						lcd_irq  = item.vblank_stat_enable;
					end else begin
						mode_new = MODE_OAM;
						lcd_irq  = item.oam_irq_enable;
					end
				end
				default: begin
					line_new = line_inc;
					if (line_inc == TOTAL_LINES) begin
						line_new = '0;
						mode_new = MODE_OAM;
						lcd_irq  = item.oam_irq_enable;
					end
				end
			endcase
		end
	end

	assign match = item.compare_irq_enable && (line_new == item.compare_line);

	always_comb begin
		if (item.lcd_enable) begin
			nxt.acc   = phase_done ? diff : sat;
			nxt.mode  = mode_new;
			nxt.line  = line_new;
			nxt.coinc = match;
		end else begin
			nxt = cur;
		end
		res.mode        = nxt.mode;
		res.line        = nxt.line;
		res.coincidence = nxt.coinc;
		res.lcd_irq     = item.lcd_enable && (lcd_irq || match);
		res.vblank_irq  = item.lcd_enable && vb_irq;
		res.draw_line   = item.lcd_enable && drawn;
	end

endmodule

/* design/lcd_mode_timing_sequencer.sv */
// ----------------------------------------------------------------------------
// LCD mode timing sequencer - top level
// Mode, line and interrupt timing of an LCD controller, one time step per
// transfer, with an input register, the sequencer state and a result register.
//
// Channel  Dir  Payload (lowest bit first)
// s_axis   in   elapsed_mcycles, lcd_enable, hblank/vblank/oam/compare enables,
//               compare_line
// m_axis   out  mode, line, coincidence, lcd_irq, vblank_irq, draw_line
//
// One step is accepted every cycle unless the result side stalls; its result
// is registered after the step passes the input register. The state
// update and the result come from the same single pass of step logic between
// the input register and the result register.
// arst_n clears valid flags and state: mode OAM scan, line 0, accumulator 0.
// A stalled result holds the input register; s_tready drops when both fill.
// ----------------------------------------------------------------------------
`include "lcd_mode_timing_sequencer_defines.svh"

module lcd_mode_timing_sequencer
	import lmts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// elapsed_mcycles[9:0], lcd_enable, hblank_irq_enable, vblank_stat_enable,
	// oam_irq_enable, compare_irq_enable, compare_line[7:0], zero pad
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// mode[1:0], line[7:0], coincidence, lcd_irq, vblank_irq, draw_line, zero pad
	output logic [OUT_W-1:0] m_tdata
);

	in_item_t   in_s1;
	logic       valid_s1;
	seq_state_t state_q;
	seq_state_t state_nxt;
	out_item_t  res_nxt;
	out_item_t  out_q;
	logic       out_valid_q;
	logic       advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// capture the incoming transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_s1 <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
		end
	end

	lmts_step u_step (
		.item (in_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// advance the sequencer state once per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.acc   <= '0;
			state_q.mode  <= MODE_OAM;
			state_q.line  <= '0;
			state_q.coinc <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_q);

	`LMTS_ASSERT(a_line_range, state_q.line < TOTAL_LINES, "line counter out of range")
	`LMTS_ASSERT(a_vblank_lines, (state_q.mode == MODE_VBLANK) == (state_q.line >= VISIBLE_LINES), "vblank mode and line disagree")
	`LMTS_ASSERT(a_draw_hblank, !(out_valid_q && out_q.draw_line) || (out_q.mode == MODE_HBLANK), "draw strobe outside hblank")
	`LMTS_ASSERT_NEXT(a_state_hold, !advance, $stable(state_q), "state changed without a step")

endmodule

/* verif/tb_lcd_mode_timing_sequencer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCD mode timing sequencer - testbench
// Drives timing steps through the input stream and checks every result
// transfer against a local model of the mode, line and interrupt timing.
// A short table of directed steps comes first, some with results typed in.
// Random steps follow, first paced and then in bursts that saturate the dot
// count and run through vblank into the next frame. Both stream sides idle
// at random. The result side also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_lcd_mode_timing_sequencer;
	import lmts_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_STEPS = 584;
	localparam int PACED_STEPS  = 200;
	localparam int HOLD_CYCLES  = 200;
	localparam int HOLD_AFTER   = 120;

	typedef struct {
		in_item_t  stim;
		bit        typed;
		out_item_t want;
	} step_row_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	logic [ACC_W-1:0]  dot_acc;
	mode_t             seq_mode;
	logic [LINE_W-1:0] seq_line;
	logic              seq_coinc;

	out_item_t expected_steps[$];
	step_row_t timing_rows[$];
	out_item_t got_step;
	out_item_t want_step;
	int        mismatches = 0;
	int        results_seen = 0;
	int        cycles = 0;
	bit        calm = 1'b0;
	bit        hold_done = 1'b0;

	lcd_mode_timing_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void reset_timing();
		dot_acc   = '0;
		seq_mode  = MODE_OAM;
		seq_line  = '0;
		seq_coinc = 1'b0;
	endfunction

	function automatic out_item_t advance_timing(in_item_t it);
		logic [ACC_W:0] sum;
		out_item_t      res;
		res = '0;
		if (it.lcd_enable) begin
			sum = {1'b0, dot_acc} + (ACC_W+1)'({it.elapsed_mcycles, 2'b00});
			dot_acc = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
			case (seq_mode)
				MODE_OAM: begin
					if (dot_acc >= OAM_DOTS) begin
						dot_acc  = dot_acc - OAM_DOTS;
						seq_mode = MODE_DRAW;
					end
				end
				MODE_DRAW: begin
					if (dot_acc >= DRAW_DOTS) begin
						dot_acc       = dot_acc - DRAW_DOTS;
						seq_mode      = MODE_HBLANK;
						res.draw_line = 1'b1;
						res.lcd_irq   = it.hblank_irq_enable;
					end
				end
				MODE_HBLANK: begin
					if (dot_acc >= HBLANK_DOTS) begin
						dot_acc  = dot_acc - HBLANK_DOTS;
						seq_line = seq_line + 1'b1;
						if (seq_line == VISIBLE_LINES) begin
							seq_mode       = MODE_VBLANK;
							res.vblank_irq = 1'b1;
							res.lcd_irq    = it.vblank_stat_enable;
						end else begin
							seq_mode    = MODE_OAM;
							res.lcd_irq = it.oam_irq_enable;
						end
					end
				end
				default: begin
					if (dot_acc >= LINE_DOTS) begin
						dot_acc  = dot_acc - LINE_DOTS;
						seq_line = seq_line + 1'b1;
						if (seq_line == TOTAL_LINES) begin
							seq_line    = '0;
							seq_mode    = MODE_OAM;
							res.lcd_irq = it.oam_irq_enable;
						end
					end
				end
			endcase
			seq_coinc = it.compare_irq_enable && (seq_line == it.compare_line);
			if (seq_coinc)
				res.lcd_irq = 1'b1;
		end
		res.mode        = seq_mode;
		res.line        = seq_line;
		res.coincidence = seq_coinc;
		return res;
	endfunction

	function automatic in_item_t make_step(int mcyc, bit en, bit hb, bit vb, bit oam,
			bit cmp, int cmp_line);
		in_item_t it;
		it.elapsed_mcycles    = MCYC_W'(mcyc);
		it.lcd_enable         = en;
		it.hblank_irq_enable  = hb;
		it.vblank_stat_enable = vb;
		it.oam_irq_enable     = oam;
		it.compare_irq_enable = cmp;
		it.compare_line       = LINE_W'(cmp_line);
		return it;
	endfunction

	function automatic out_item_t make_result(mode_t m, int line, bit coinc, bit lcd,
			bit vb, bit drawn);
		out_item_t res;
		res.mode        = m;
		res.line        = LINE_W'(line);
		res.coincidence = coinc;
		res.lcd_irq     = lcd;
		res.vblank_irq  = vb;
		res.draw_line   = drawn;
		return res;
	endfunction

	function automatic in_item_t random_step(bit burst);
		in_item_t it;
		int       pick;
		it = in_item_t'($bits(in_item_t)'($urandom));
		it.lcd_enable = ($urandom_range(99) < 90);
		pick = $urandom_range(99);
		if (burst) begin
			if (pick < 70)
				it.elapsed_mcycles = MCYC_W'($urandom_range(1023, 114));
			else if (pick < 85)
				it.elapsed_mcycles = '1;
			else
				it.elapsed_mcycles = MCYC_W'($urandom_range(1023));
		end else begin
			if (pick < 60)
				it.elapsed_mcycles = MCYC_W'($urandom_range(57));
			else if (pick < 85) begin
				case ($urandom_range(3))
					0: it.elapsed_mcycles = MCYC_W'(OAM_DOTS / 4);
					1: it.elapsed_mcycles = MCYC_W'(DRAW_DOTS / 4);
					2: it.elapsed_mcycles = MCYC_W'(HBLANK_DOTS / 4);
					default: it.elapsed_mcycles = MCYC_W'(LINE_DOTS / 4);
				endcase
			end else if (pick < 95)
				it.elapsed_mcycles = '0;
			else
				it.elapsed_mcycles = MCYC_W'($urandom_range(1023));
		end
		// aim the compare value at the line the step is likely to land on
		case ($urandom_range(3))
			0: it.compare_line = seq_line;
			1: it.compare_line = seq_line + 1'b1;
			2: it.compare_line = LINE_W'($urandom_range(153));
			default: it.compare_line = LINE_W'($urandom_range(255));
		endcase
		return it;
	endfunction

	task automatic sender_gap();
		if (!calm && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 23)
				@(posedge clk);
		end
	endtask

	task automatic transfer_step(in_item_t it, bit typed, out_item_t want);
		out_item_t predicted;
		sender_gap();
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'(it);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = advance_timing(it);
		expected_steps.push_back(typed ? want : predicted);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_steps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	initial begin
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		arst_n   <= 1'b0;
		reset_timing();

		// disabled step freezes everything, even with a compare match waiting
		timing_rows.push_back(step_row_t'{make_step(1023, 0, 1, 1, 1, 1, 0), 1'b1,
			make_result(MODE_OAM, 0, 0, 0, 0, 0)});
		timing_rows.push_back(step_row_t'{make_step(0, 1, 0, 0, 0, 1, 0), 1'b1,
			make_result(MODE_OAM, 0, 1, 1, 0, 0)});
		timing_rows.push_back(step_row_t'{make_step(1023, 1, 1, 0, 0, 0, 255), 1'b1,
			make_result(MODE_DRAW, 0, 0, 0, 0, 0)});
		timing_rows.push_back(step_row_t'{make_step(0, 1, 1, 0, 0, 0, 255), 1'b1,
			make_result(MODE_HBLANK, 0, 0, 1, 0, 1)});
		timing_rows.push_back(step_row_t'{make_step(0, 1, 0, 0, 1, 1, 1), 1'b1,
			make_result(MODE_OAM, 1, 1, 1, 0, 0)});
		// held flag stays visible while disabled
		timing_rows.push_back(step_row_t'{make_step(0, 0, 1, 1, 1, 1, 1), 1'b1,
			make_result(MODE_OAM, 1, 1, 0, 0, 0)});
		timing_rows.push_back(step_row_t'{make_step(0, 1, 0, 0, 0, 0, 1), 1'b0, '0});
		timing_rows.push_back(step_row_t'{make_step(0, 1, 0, 0, 0, 1, 255), 1'b0, '0});
		timing_rows.push_back(step_row_t'{make_step(0, 1, 0, 0, 0, 1, 2), 1'b0, '0});
		timing_rows.push_back(step_row_t'{make_step(341, 1, 1, 1, 1, 0, 170), 1'b0, '0});
		timing_rows.push_back(step_row_t'{make_step(682, 1, 0, 1, 0, 1, 85), 1'b0, '0});
		timing_rows.push_back(step_row_t'{make_step(1, 1, 1, 0, 1, 1, 2), 1'b0, '0});
		timing_rows.push_back(step_row_t'{make_step(0, 1, 1, 1, 1, 1, 3), 1'b0, '0});
		timing_rows.push_back(step_row_t'{make_step(1023, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		timing_rows.push_back(step_row_t'{make_step(0, 1, 0, 1, 1, 1, 3), 1'b0, '0});
		timing_rows.push_back(step_row_t'{make_step(512, 1, 1, 1, 1, 1, 4), 1'b0, '0});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (timing_rows[i])
			transfer_step(timing_rows[i].stim, timing_rows[i].typed, timing_rows[i].want);

		// hold the sender until every result is back
		drain_results();

		for (int i = 0; i < RANDOM_STEPS; i++) begin
			calm = (i >= 300 && i < 400);
			transfer_step(random_step(i >= PACED_STEPS), 1'b0, '0);
		end
		calm = 1'b0;

		drain_results();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 23);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			got_step = out_item_t'(m_tdata[$bits(out_item_t)-1:0]);
			if (expected_steps.size() == 0) begin
				$error("unexpected result transfer, tdata %h", m_tdata);
				mismatches++;
			end else begin
				want_step = expected_steps.pop_front();
				check_field("mode", want_step.mode, got_step.mode);
				check_field("line", want_step.line, got_step.line);
				check_field("coincidence", want_step.coincidence, got_step.coincidence);
				check_field("lcd_irq", want_step.lcd_irq, got_step.lcd_irq);
				check_field("vblank_irq", want_step.vblank_irq, got_step.vblank_irq);
				check_field("draw_line", want_step.draw_line, got_step.draw_line);
				check_field("pad", '0, m_tdata[OUT_W-1:$bits(out_item_t)]);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule

/* files.f */
+incdir+design
design/lmts_pkg.sv
design/lmts_step.sv
design/lcd_mode_timing_sequencer.sv
verif/tb_lcd_mode_timing_sequencer.sv
